/* rtl/irattl_pkg.sv */
// ----------------------------------------------------------------------------
// irattl_pkg
// Shared types and constants of the ID remap allocator with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package irattl_pkg;

  // Fixed field widths
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned AGE_W      = 8;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Parameter defaults
  localparam int unsigned POOL_SLOTS_DEF = 32;
  localparam int unsigned ID_WIDTH_DEF   = 16;

  // Register reset values
  localparam logic [AGE_W-1:0]   TTL_RST   = 8'd10;
  localparam logic [FIELD_W-1:0] BASE_RST  = 16'd0;
  localparam logic [CNT_W-1:0]   COUNT_RST = 6'd32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TTL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  typedef enum logic {
    OP_ASSIGN = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KIND_EXISTING  = 3'd0,
    KIND_NEW       = 3'd1,
    KIND_EXHAUSTED = 3'd2,
    KIND_RELEASED  = 3'd3,
    KIND_DONE      = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_ASSIGN  = 4'b0010,
    ST_TICK    = 4'b0100,
    ST_RELEASE = 4'b1000
  } state_e;

endpackage

`default_nettype wire

/* rtl/irattl_slot_mem.sv */
// ----------------------------------------------------------------------------
// irattl_slot_mem
// Per-slot source ID and age storage: one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module irattl_slot_mem #(
  parameter int unsigned POOL_SLOTS = irattl_pkg::POOL_SLOTS_DEF,
  parameter int unsigned SRC_W      = irattl_pkg::ID_WIDTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         src_we_i,
  input  logic                                         age_we_i,
  input  logic [((POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1)-1:0] wr_addr_i,
  input  logic [SRC_W-1:0]                             wr_src_i,
  input  logic [irattl_pkg::AGE_W-1:0]                 wr_age_i,
  input  logic [((POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1)-1:0] rd_addr_i,
  output logic [SRC_W-1:0]                             rd_src_o,
  output logic [irattl_pkg::AGE_W-1:0]                 rd_age_o
);
  import irattl_pkg::*;

  logic [SRC_W-1:0] src_mem [POOL_SLOTS];
  logic [AGE_W-1:0] age_mem [POOL_SLOTS];

  always_ff @(posedge clk_i) begin
    if (src_we_i) begin
      src_mem[wr_addr_i] <= wr_src_i;
    end
    rd_src_o <= src_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (age_we_i) begin
      age_mem[wr_addr_i] <= wr_age_i;
    end
    rd_age_o <= age_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

/* rtl/id_remap_allocator_with_ttl_unit.sv */
// ----------------------------------------------------------------------------
// id_remap_allocator_with_ttl_unit
// Maps input IDs onto a compact output ID pool and releases stale mappings.
// ----------------------------------------------------------------------------
// Pulse start_i while busy_o is low to issue a request. Every request walks
// the slot memory one slot per cycle through its single read port. An assign
// request returns one result. A tick request ages every live slot that has not
// expired in one walk, then finds each expired mapping in ascending source
// order with a further walk per release, plus one closing walk that finds
// nothing; when nothing expires, the ageing walk ends with a done result.
// Each result is shown for one cycle on result_valid_o and must be taken then;
// busy_o is low again in the cycle that carries the result with last_o set.
// Write registers only while busy_o is low.
`default_nettype none

module id_remap_allocator_with_ttl_unit #(
  parameter int unsigned POOL_SLOTS = irattl_pkg::POOL_SLOTS_DEF,
  parameter int unsigned ID_WIDTH   = irattl_pkg::ID_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                operation_i,
  input  logic [irattl_pkg::FIELD_W-1:0]      source_id_i,
  input  logic                                cfg_we_i,
  input  logic [irattl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [irattl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                                result_valid_o,
  output irattl_pkg::kind_e                   kind_o,
  output logic [irattl_pkg::FIELD_W-1:0]      mapped_source_o,
  output logic [irattl_pkg::FIELD_W-1:0]      mapped_output_o,
  output logic                                last_o
);
  import irattl_pkg::*;

  localparam int unsigned IdxW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned PtrW = $clog2(POOL_SLOTS + 1);
  localparam int unsigned SrcW = (ID_WIDTH < FIELD_W) ? ID_WIDTH : FIELD_W;
  localparam int unsigned CmpW = CNT_W + 1;
  localparam logic [PtrW-1:0]    PtrEnd  = PtrW'(POOL_SLOTS);
  localparam logic [FIELD_W-1:0] OidMask = FIELD_W'((64'd1 << SrcW) - 64'd1);

  state_e                 state_q, state_d;
  logic [PtrW-1:0]        ptr_q, ptr_d;
  logic                   pend_q, pend_d;
  logic [IdxW-1:0]        pidx_q, pidx_d;
  logic [SrcW-1:0]        src_q, src_d;
  logic                   hit_q, hit_d;
  logic [IdxW-1:0]        hit_idx_q, hit_idx_d;
  logic                   free_q, free_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;
  logic                   best_q, best_d;
  logic [IdxW-1:0]        best_idx_q, best_idx_d;
  logic [SrcW-1:0]        best_src_q, best_src_d;
  logic [POOL_SLOTS-1:0]  valid_q, valid_d;
  logic [POOL_SLOTS-1:0]  exp_q, exp_d;
  logic [AGE_W-1:0]       ttl_q, ttl_d;
  logic [FIELD_W-1:0]     base_q, base_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  kind_e                  out_kind_q, out_kind_d;
  logic [FIELD_W-1:0]     out_src_q, out_src_d;
  logic [FIELD_W-1:0]     out_oid_q, out_oid_d;
  logic                   out_last_q, out_last_d;

  logic                   src_we, age_we;
  logic [IdxW-1:0]        wr_addr, rd_addr;
  logic [SrcW-1:0]        wr_src, rd_src;
  logic [AGE_W-1:0]       wr_age, rd_age;
  logic                   scan_done;
  logic                   in_limit;
  logic [IdxW-1:0]        oid_idx;
  logic [FIELD_W-1:0]     oid;

  irattl_slot_mem #(
    .POOL_SLOTS (POOL_SLOTS),
    .SRC_W      (SrcW)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .src_we_i  (src_we),
    .age_we_i  (age_we),
    .wr_addr_i (wr_addr),
    .wr_src_i  (wr_src),
    .wr_age_i  (wr_age),
    .rd_addr_i (rd_addr),
    .rd_src_o  (rd_src),
    .rd_age_o  (rd_age)
  );

  assign rd_addr   = ptr_q[IdxW-1:0];
  assign scan_done = (ptr_q == PtrEnd) && !pend_q;
  assign in_limit  = CmpW'(pidx_q) < CmpW'(count_q);
  assign oid_idx   = (state_q == ST_RELEASE) ? best_idx_q : (hit_q ? hit_idx_q : free_idx_q);
  assign oid       = (base_q + FIELD_W'(oid_idx)) & OidMask;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    src_d       = src_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_src_d  = best_src_q;
    valid_d     = valid_q;
    exp_d       = exp_q;
    ttl_d       = ttl_q;
    base_d      = base_q;
    count_d     = count_q;
    out_valid_d = 1'b0;
    out_kind_d  = out_kind_q;
    out_src_d   = out_src_q;
    out_oid_d   = out_oid_q;
    out_last_d  = out_last_q;
    src_we      = 1'b0;
    age_we      = 1'b0;
    wr_addr     = pidx_q;
    wr_src      = src_q;
    wr_age      = rd_age + AGE_W'(1);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TTL:   ttl_d   = cfg_data_i[AGE_W-1:0];
        CFG_BASE:  base_d  = cfg_data_i[FIELD_W-1:0];
        CFG_COUNT: count_d = cfg_data_i[CNT_W-1:0];
        default:   ;
      endcase
    end

    // Advance the slot walk: issue a read, process its data in the next cycle
    if (state_q != ST_IDLE) begin
      if (ptr_q != PtrEnd) begin
        pend_d = 1'b1;
        pidx_d = ptr_q[IdxW-1:0];
        ptr_d  = ptr_q + PtrW'(1);
      end else begin
        pend_d = 1'b0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ptr_d  = '0;
          pend_d = 1'b0;
          src_d  = source_id_i[SrcW-1:0];
          hit_d  = 1'b0;
          free_d = 1'b0;
          best_d = 1'b0;
          if (operation_i == OP_TICK) begin
            exp_d   = '0;
            state_d = ST_TICK;
          end else begin
            state_d = ST_ASSIGN;
          end
        end
      end

      ST_ASSIGN: begin
        if (pend_q) begin
          if (valid_q[pidx_q] && (rd_src == src_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = pidx_q;
          end
          // take the lowest free slot below the pool count
          if (!valid_q[pidx_q] && !free_q && in_limit) begin
            free_d     = 1'b1;
            free_idx_d = pidx_q;
          end
        end
        if (scan_done) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_src_d   = FIELD_W'(src_q);
          if (hit_q) begin
            age_we     = 1'b1;
            wr_addr    = hit_idx_q;
            wr_age     = '0;
            out_kind_d = KIND_EXISTING;
            out_oid_d  = oid;
          end else if (free_q) begin
            src_we              = 1'b1;
            age_we              = 1'b1;
            wr_addr             = free_idx_q;
            wr_age              = '0;
            valid_d[free_idx_q] = 1'b1;
            out_kind_d          = KIND_NEW;
            out_oid_d           = oid;
          end else begin
            out_kind_d = KIND_EXHAUSTED;
            out_oid_d  = '0;
          end
        end
      end

      ST_TICK: begin
        if (pend_q && valid_q[pidx_q]) begin
          if (rd_age >= ttl_q) begin
            exp_d[pidx_q] = 1'b1;
          end else begin
            age_we = 1'b1;
          end
        end
        if (scan_done) begin
          if (exp_q == '0) begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b1;
            out_kind_d  = KIND_DONE;
            out_src_d   = '0;
            out_oid_d   = '0;
            out_last_d  = 1'b1;
          end else begin
            state_d = ST_RELEASE;
            ptr_d   = '0;
            pend_d  = 1'b0;
            best_d  = 1'b0;
          end
        end
      end

      ST_RELEASE: begin
        // hold the smallest source among the expired slots
        if (pend_q && exp_q[pidx_q] && (!best_q || (rd_src < best_src_q))) begin
          best_d     = 1'b1;
          best_idx_d = pidx_q;
          best_src_d = rd_src;
        end
        if (scan_done) begin
          out_valid_d = 1'b1;
          if (best_q) begin
            out_kind_d          = KIND_RELEASED;
            out_src_d           = FIELD_W'(best_src_q);
            out_oid_d           = oid;
            out_last_d          = 1'b0;
            valid_d[best_idx_q] = 1'b0;
            exp_d[best_idx_q]   = 1'b0;
            ptr_d               = '0;
            pend_d              = 1'b0;
            best_d              = 1'b0;
          end else begin
            state_d    = ST_IDLE;
            out_kind_d = KIND_DONE;
            out_src_d  = '0;
            out_oid_d  = '0;
            out_last_d = 1'b1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      best_q      <= 1'b0;
      valid_q     <= '0;
      exp_q       <= '0;
      ttl_q       <= TTL_RST;
      base_q      <= BASE_RST;
      count_q     <= COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      best_q      <= best_d;
      valid_q     <= valid_d;
      exp_q       <= exp_d;
      ttl_q       <= ttl_d;
      base_q      <= base_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    src_q      <= src_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    best_idx_q <= best_idx_d;
    best_src_q <= best_src_d;
    out_kind_q <= out_kind_d;
    out_src_q  <= out_src_d;
    out_oid_q  <= out_oid_d;
    out_last_q <= out_last_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign result_valid_o  = out_valid_q;
  assign kind_o          = out_kind_q;
  assign mapped_source_o = out_src_q;
  assign mapped_output_o = out_oid_q;
  assign last_o          = out_last_q;

  // The final result of a request coincides with the return to idle
  a_last_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o != busy_o))
    else $error("last result does not match busy state");

  // Only live mappings can be marked for release
  a_expire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q & ~valid_q) == '0)
    else $error("expire mark on an empty slot");

  // No slot read is outstanding once idle
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q != ST_IDLE))
    else $error("slot read pending while idle");

endmodule

`default_nettype wire
